### rtl/hbct_pkg.sv
// ----------------------------------------------------------------------------
// hbct_pkg
// Shared types and constants for the hashed buffer cache tag manager.
// ----------------------------------------------------------------------------
package hbct_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int BUCKETS_DEF = 13;

  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int HOME_W   = 4;
  localparam int CNT_W    = 6;
  localparam int TIME_W   = 32;
  localparam int BUFIDX_W = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  localparam logic [1:0] ACT_GET     = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_PIN     = 2'd2;
  localparam logic [1:0] ACT_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBUF = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  typedef struct packed {
    logic              cv;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [HOME_W-1:0] home;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/hashed_buffer_cache_tags.sv
// ----------------------------------------------------------------------------
// hashed_buffer_cache_tags
// Tag manager for a hashed disk block buffer cache, one request word at a time.
// ----------------------------------------------------------------------------
// A get runs, from acceptance to result, a nibble-serial bucket remainder,
// then one entry a cycle through the tag RAM read port, then decision and
// write-back. Release, pin and unpin read the entry, then execute.
// A new word is accepted the cycle after the result is registered, or later
// while a result waits.
// Reset is synchronous; per-entry valid flops clear at once, so no clearing pass.
module hashed_buffer_cache_tags
  import hbct_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // device_id[7:0], block_number[39:8], buffer_index[44:40], current_time[76:45]
  input  logic [79:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // entry_index[4:0], hit[5], needs_fill[6], status[8:7]
  output logic [15:0] m_axis_tdata
);

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_SCAN, S_DRAIN, S_DECIDE, S_OP_RD, S_OP_EXEC, S_FINISH
  } state_t;

  state_t state;

  logic [1:0]          op_action;
  logic [DEV_W-1:0]    op_dev;
  logic [BLK_W-1:0]    op_blk;
  logic [BLK_W-1:0]    blk_sh;
  logic [TIME_W-1:0]   op_time;
  logic [IW-1:0]       op_addr;
  logic [HOME_W-1:0]   home;
  logic [HOME_W-1:0]   home_next;
  logic [2:0]          mod_cnt;

  logic [IW-1:0]       scan_idx;
  logic                chk_valid;
  logic [IW-1:0]       chk_idx;

  logic                hit_found;
  logic [IW-1:0]       hit_idx;
  logic [CNT_W-1:0]    hit_cnt;
  logic                hit_cv;
  logic                cand_found;
  logic [IW-1:0]       cand_idx;
  logic [HOME_W-1:0]   cand_dist;
  logic [TIME_W-1:0]   cand_time;

  logic [4:0]          res_idx;
  logic                res_hit;
  logic                res_fill;
  logic [1:0]          res_status;

  logic [ENTRIES-1:0]  entry_ok;
  logic                ok_q;
  logic [ENTRY_W-1:0]  rd_data;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_ent;
  entry_t              ent;

  logic [IW+4:0]       in_buf_wide;
  logic                in_range;
  logic [HOME_W-1:0]   bkt_dist;
  logic                is_match;
  logic                is_better;

  function automatic logic [4:0] to_out(input logic [IW-1:0] i);
    logic [IW+4:0] w;
    w = {5'b0, i};
    return w[4:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  hbct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign in_buf_wide   = {{IW{1'b0}}, s_axis_tdata[44:40]};
  assign in_range      = (in_buf_wide < (IW+5)'(ENTRIES));
  assign rd_addr       = (state == S_SCAN) ? scan_idx : op_addr;
  assign ent           = ok_q ? entry_t'(rd_data) : entry_t'('0);

  always_comb begin
    logic [7:0] x;
    x = {home, blk_sh[BLK_W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (x >= 8'(BUCKETS << k)) begin
        x = x - 8'(BUCKETS << k);
      end
    end
    home_next = x[HOME_W-1:0];
  end

  always_comb begin
    logic [4:0] d;
    if (ent.home >= home) begin
      d = {1'b0, ent.home} - {1'b0, home};
    end else begin
      d = {1'b0, ent.home} + 5'(BUCKETS) - {1'b0, home};
    end
    bkt_dist  = d[HOME_W-1:0];
    is_match  = (ent.home == home) && (ent.dev == op_dev) && (ent.blk == op_blk);
    is_better = (ent.cnt == '0) &&
                (!cand_found || ({bkt_dist, ent.stamp} < {cand_dist, cand_time}));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = op_addr;
    wr_ent  = ent;
    if (state == S_DECIDE) begin
      wr_ent.cv    = 1'b1;
      wr_ent.dev   = op_dev;
      wr_ent.blk   = op_blk;
      wr_ent.home  = home;
      wr_ent.stamp = op_time;
      if (hit_found) begin
        wr_en      = 1'b1;
        wr_addr    = hit_idx;
        wr_ent.cnt = cnt_up(hit_cnt);
      end else begin
        wr_en      = cand_found;
        wr_addr    = cand_idx;
        wr_ent.cnt = CNT_W'(1);
      end
    end else if (state == S_OP_EXEC) begin
      if (op_action == ACT_PIN) begin
        wr_en      = 1'b1;
        wr_ent.cnt = cnt_up(ent.cnt);
      end else if (ent.cnt != '0) begin
        wr_en      = 1'b1;
        wr_ent.cnt = ent.cnt - CNT_W'(1);
        if (op_action == ACT_RELEASE) begin
          wr_ent.stamp = op_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_q <= entry_ok[rd_addr];
    if (rst) begin
      state         <= S_IDLE;
      entry_ok      <= '0;
      m_axis_tvalid <= 1'b0;
      chk_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_ok[wr_addr] <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready && (state != S_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end

      if (chk_valid) begin
        if (is_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= chk_idx;
          hit_cnt   <= ent.cnt;
          hit_cv    <= ent.cv;
        end
        if (is_better) begin
          cand_found <= 1'b1;
          cand_idx   <= chk_idx;
          cand_dist  <= bkt_dist;
          cand_time  <= ent.stamp;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_action  <= s_axis_tuser;
            op_dev     <= s_axis_tdata[7:0];
            op_blk     <= s_axis_tdata[39:8];
            blk_sh     <= s_axis_tdata[39:8];
            op_addr    <= in_buf_wide[IW-1:0];
            op_time    <= s_axis_tdata[76:45];
            home       <= '0;
            mod_cnt    <= '0;
            hit_found  <= 1'b0;
            cand_found <= 1'b0;
            res_idx    <= s_axis_tdata[44:40];
            res_hit    <= 1'b0;
            res_fill   <= 1'b0;
            res_status <= ST_OK;
            if (s_axis_tuser == ACT_GET) begin
              state <= S_MOD;
            end else if (in_range) begin
              state <= S_OP_RD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_MOD: begin
          home    <= home_next;
          blk_sh  <= {blk_sh[BLK_W-5:0], 4'b0};
          mod_cnt <= mod_cnt + 3'd1;
          if (mod_cnt == 3'd7) begin
            scan_idx <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_valid <= 1'b1;
          chk_idx   <= scan_idx;
          if (scan_idx == IW'(ENTRIES - 1)) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_DRAIN: begin
          chk_valid <= 1'b0;
          state     <= S_DECIDE;
        end
        S_DECIDE: begin
          if (hit_found) begin
            res_idx  <= to_out(hit_idx);
            res_hit  <= 1'b1;
            res_fill <= !hit_cv;
          end else if (cand_found) begin
            res_idx  <= to_out(cand_idx);
            res_fill <= 1'b1;
          end else begin
            res_idx    <= '0;
            res_status <= ST_NOBUF;
          end
          state <= S_FINISH;
        end
        S_OP_RD: begin
          state <= S_OP_EXEC;
        end
        S_OP_EXEC: begin
          if (op_action != ACT_PIN && ent.cnt == '0) begin
            res_status <= ST_ZERO;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'b0, res_status, res_fill, res_hit, res_idx};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/hbct_ram.sv
// ----------------------------------------------------------------------------
// hbct_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
